FILE: hdl/atan2_poly_approx_defines.svh
// Assertion macros for the block that checks itself.
`ifndef ATAN2_POLY_APPROX_DEFINES_SVH
`define ATAN2_POLY_APPROX_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define A2P_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("a2p check failed");

// Next-cycle implication, checked outside reset.
`define A2P_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("a2p check failed");

`endif

FILE: hdl/a2p_pkg.sv
// Shared widths, fixed-point constants and helpers for the atan2 pipeline.
package a2p_pkg;

  localparam int OPERAND_WIDTH   = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

  // Internal Q.30 format
  localparam int QF  = 30;
  localparam int QW  = QF + 1;              // quotient / polynomial word
  localparam int MW  = OPERAND_WIDTH;       // operand magnitude
  localparam int RW  = OPERAND_WIDTH + 1;   // divider remainder
  localparam int SH  = QF - ANGLE_FRAC_BITS;
  localparam int POLY_STAGES = 5;
  localparam int TAIL_STAGES = 3;
  localparam int LATENCY = 1 + QW + POLY_STAGES + TAIL_STAGES;

  localparam logic [31:0] K_ONE    = 32'd1073741824;
  localparam logic [31:0] K_C0     = 32'd16106127;
  localparam logic [31:0] K_C1     = 32'd1107135195;
  localparam logic [31:0] K_C2     = 32'd280031868;
  localparam logic [31:0] K_S1     = 32'd357556027;
  localparam logic [31:0] K_S2     = 32'd214748365;
  localparam logic [31:0] K_S3     = 32'd153437707;
  localparam logic [31:0] K_HALFPI = 32'd1686629713;
  localparam logic [31:0] K_PI     = 32'd3373259426;

  localparam logic [ANGLE_WIDTH-1:0] PI_OUT =
    ANGLE_WIDTH'((33'(K_PI) + (33'd1 << (SH - 1))) >> SH);

  // Special-case result selected up front
  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_HALFPI,
    SP_PI
  } spec_t;

  typedef struct packed {
    spec_t spec;
    logic  neg;     // result sign
    logic  denneg;  // fold into the left half plane
    logic  swap;    // reciprocal ratio used
    logic  big;     // quadratic segment
  } ctl_t;

  // Unsigned Q.30 product, truncated
  function automatic logic [QW-1:0] qmul(input logic [QW-1:0] x, input logic [QW-1:0] y);
    logic [2*QW-1:0] p;
    p = {{QW{1'b0}}, x} * {{QW{1'b0}}, y};
    return p[QF +: QW];
  endfunction

endpackage

FILE: hdl/atan2_poly_approx.sv
// Pipelined four-quadrant arctangent with piecewise polynomial core.
//
// Takes one operand pair per clock when start is high (busy is never
// raised) and returns the angle, Q3.13 radians, with done high for one
// cycle once the beat has passed one input stage, a 31-stage restoring
// divider (one quotient bit per stage), five multiplier stages for the
// polynomial and three stages for quadrant folding, rounding and
// saturation. Results cannot be held off; every beat is delivered once.
module atan2_poly_approx (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [a2p_pkg::OPERAND_WIDTH-1:0] numerator,
  input  logic signed [a2p_pkg::OPERAND_WIDTH-1:0] denominator,
  output logic                                     done,
  output logic signed [a2p_pkg::ANGLE_WIDTH-1:0]   angle
);
  import a2p_pkg::*;
  `include "atan2_poly_approx_defines.svh"

  // Input decode: magnitudes, range select, special cases
  logic [MW-1:0]   mag_a, mag_b;
  logic [MW+2:0]   a5, b7;
  logic            num_zero, den_zero, sel_swap, sel_big;
  ctl_t            ctl_in;

  always_comb begin
    mag_a    = numerator[OPERAND_WIDTH-1] ? (~numerator + 1'b1) : numerator;
    mag_b    = denominator[OPERAND_WIDTH-1] ? (~denominator + 1'b1) : denominator;
    num_zero = (numerator == '0);
    den_zero = (denominator == '0);
    a5       = {1'b0, mag_a, 2'b00} + {3'b000, mag_a};
    b7       = {mag_b, 3'b000} - {3'b000, mag_b};
    sel_swap = a5 > b7;
    sel_big  = sel_swap ? ({mag_b, 1'b0} >= {1'b0, mag_a})
                        : ({mag_a, 1'b0} >= {1'b0, mag_b});
    ctl_in.neg    = numerator[OPERAND_WIDTH-1];
    ctl_in.denneg = denominator[OPERAND_WIDTH-1];
    ctl_in.swap   = sel_swap;
    ctl_in.big    = sel_big;
    priority if (den_zero) ctl_in.spec = num_zero ? SP_ZERO : SP_HALFPI;
    else if (num_zero)     ctl_in.spec = denominator[OPERAND_WIDTH-1] ? SP_PI : SP_ZERO;
    else                   ctl_in.spec = SP_NONE;
  end

  assign busy = 1'b0;

  // Divider pipeline, stage 0 is the input register
  logic            dv_vld [0:QW];
  ctl_t            dv_ctl [0:QW];
  logic [RW-1:0]   dv_rem [0:QW];
  logic [MW-1:0]   dv_dvs [0:QW];
  logic [QW-1:0]   dv_quo [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= start && !busy;
    end
    dv_ctl[0] <= ctl_in;
    dv_rem[0] <= {1'b0, (sel_swap ? mag_b : mag_a)};
    dv_dvs[0] <= sel_swap ? mag_a : mag_b;
    dv_quo[0] <= '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic          qbit;
    logic [RW-1:0] diff;

    // One restoring step: compare, subtract, shift
    always_comb begin
      qbit = dv_rem[i] >= {1'b0, dv_dvs[i]};
      diff = qbit ? (dv_rem[i] - {1'b0, dv_dvs[i]}) : dv_rem[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else begin
        dv_vld[i+1] <= dv_vld[i];
      end
      dv_ctl[i+1] <= dv_ctl[i];
      dv_rem[i+1] <= {diff[RW-2:0], 1'b0};
      dv_dvs[i+1] <= dv_dvs[i];
      dv_quo[i+1] <= {dv_quo[i][QW-2:0], qbit};
    end
  end

  // Polynomial stages
  logic          m1_vld, m2_vld, m3_vld, m4_vld, m5_vld;
  ctl_t          m1_ctl, m2_ctl, m3_ctl, m4_ctl, m5_ctl;
  logic [QW-1:0] m1_t, m2_t, m3_t, m4_t;
  logic [QW-1:0] m1_s, m2_s, m3_s;
  logic [QW-1:0] m1_bq, m2_q, m3_bm, m4_bm, m5_bm;
  logic [QW-1:0] m2_x1, m3_x2, m4_x3, m5_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      m4_vld <= 1'b0;
      m5_vld <= 1'b0;
    end else begin
      m1_vld <= dv_vld[QW];
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      m4_vld <= m3_vld;
      m5_vld <= m4_vld;
    end
    // square and linear term of the quadratic
    m1_ctl <= dv_ctl[QW];
    m1_t   <= dv_quo[QW];
    m1_s   <= qmul(dv_quo[QW], dv_quo[QW]);
    m1_bq  <= qmul(dv_quo[QW], K_C2[QW-1:0]);
    // cubic coefficient term, quadratic slope
    m2_ctl <= m1_ctl;
    m2_t   <= m1_t;
    m2_s   <= m1_s;
    m2_x1  <= qmul(m1_s, K_S3[QW-1:0]);
    m2_q   <= K_C1[QW-1:0] - m1_bq;
    // second Horner step, quadratic product
    m3_ctl <= m2_ctl;
    m3_t   <= m2_t;
    m3_s   <= m2_s;
    m3_x2  <= qmul(m2_s, K_S2[QW-1:0] - m2_x1);
    m3_bm  <= qmul(m2_t, m2_q);
    // third Horner step
    m4_ctl <= m3_ctl;
    m4_t   <= m3_t;
    m4_x3  <= qmul(m3_s, K_S1[QW-1:0] - m3_x2);
    m4_bm  <= m3_bm;
    // final product with t
    m5_ctl <= m4_ctl;
    m5_y   <= qmul(m4_t, K_ONE[QW-1:0] - m4_x3);
    m5_bm  <= m4_bm;
  end

  // Tail: reciprocal fold, half-plane fold, round and saturate
  logic          f1_vld, f2_vld;
  ctl_t          f1_ctl;
  logic [QW-1:0] f1_m;
  logic          f2_neg;
  logic [31:0]   f2_mag;
  logic [QW-1:0] atan_t;
  logic [31:0]   mag_next;
  logic [32:0]   rnd_sum;
  logic [ANGLE_WIDTH-1:0] rnd_o, sat_o;

  always_comb begin
    atan_t = m5_ctl.big ? (K_C0[QW-1:0] + m5_bm) : m5_y;
    unique case (f1_ctl.spec)
      SP_ZERO:   mag_next = '0;
      SP_HALFPI: mag_next = K_HALFPI;
      SP_PI:     mag_next = K_PI;
      default:   mag_next = f1_ctl.denneg ? (K_PI - {1'b0, f1_m}) : {1'b0, f1_m};
    endcase
    rnd_sum = {1'b0, f2_mag} + (33'd1 << (SH - 1));
    rnd_o   = rnd_sum[32:SH];
    sat_o   = (rnd_o > PI_OUT) ? PI_OUT : rnd_o;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      f1_vld <= m5_vld;
      f2_vld <= f1_vld;
      done   <= f2_vld;
    end
    f1_ctl <= m5_ctl;
    f1_m   <= m5_ctl.swap ? (K_HALFPI[QW-1:0] - atan_t) : atan_t;
    f2_neg <= f1_ctl.neg;
    f2_mag <= mag_next;
    angle  <= f2_neg ? (~sat_o + 1'b1) : sat_o;
  end

  // Checks
  `A2P_ASSERT_NOW(a_done_after_start, done, $past(start, LATENCY))
  `A2P_ASSERT_NOW(a_angle_range, done,
    (angle <= $signed(PI_OUT)) && (angle >= -$signed(PI_OUT)))
  `A2P_ASSERT_NOW(a_origin_zero,
    done && ($past(numerator, LATENCY) == '0) && ($past(denominator, LATENCY) == '0),
    angle == '0)
  `A2P_ASSERT_NEXT(a_busy_low, 1'b1, !busy)

endmodule

FILE: sim/atan2_poly_approx_checker.sv
// Checker for the atan2 block: predicts each angle and compares the done beats.
module atan2_poly_approx_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic                                     busy,
  input  logic signed [a2p_pkg::OPERAND_WIDTH-1:0] numerator,
  input  logic signed [a2p_pkg::OPERAND_WIDTH-1:0] denominator,
  input  logic                                     done,
  input  logic signed [a2p_pkg::ANGLE_WIDTH-1:0]   angle,
  output int                                       fail_count,
  output int                                       pending
);
  import a2p_pkg::*;

  logic [ANGLE_WIDTH-1:0] angle_q[$];

  // Q.30 magnitude product, truncated
  function automatic longint fx_mul(input longint a, input longint b);
    longint ma, mb, p;
    logic sn;
    sn = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb) >>> QF;
    return sn ? -p : p;
  endfunction

  // Polynomial arctangent of a non-negative Q.30 ratio
  function automatic longint atan_core(input longint t, input logic quad);
    longint s, p;
    if (quad) begin
      return longint'(K_C0) + fx_mul(t, longint'(K_C1) - ((longint'(K_C2) * t) >>> QF));
    end
    s = (t * t) >>> QF;
    p = -longint'(K_S3);
    p = longint'(K_S2) + fx_mul(s, p);
    p = -longint'(K_S1) + fx_mul(s, p);
    p = longint'(K_ONE) + fx_mul(s, p);
    return fx_mul(t, p);
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] predict_angle(input longint y, input longint x);
    longint a, b, v, m, r, mag, o, pio;
    a = (y < 0) ? -y : y;
    b = (x < 0) ? -x : x;
    pio = (longint'(K_PI) + (64'sd1 << (SH - 1))) >>> SH;
    if (x == 0) v = (y > 0) ? longint'(K_HALFPI) : ((y < 0) ? -longint'(K_HALFPI) : 0);
    else if (y == 0) v = (x < 0) ? longint'(K_PI) : 0;
    else begin
      if (5 * a > 7 * b) begin
        r = (b <<< QF) / a;
        m = longint'(K_HALFPI) - atan_core(r, 2 * b >= a);
      end else begin
        r = (a <<< QF) / b;
        m = atan_core(r, 2 * a >= b);
      end
      v = ((y < 0) != (x < 0)) ? -m : m;
      if (x < 0) v = v + ((y > 0) ? longint'(K_PI) : -longint'(K_PI));
    end
    mag = (v < 0) ? -v : v;
    o = (mag + (64'sd1 << (SH - 1))) >>> SH;
    if (o > pio) o = pio;
    return (v < 0) ? ANGLE_WIDTH'(-o) : ANGLE_WIDTH'(o);
  endfunction

  assign pending = angle_q.size();

  // Predict on accepted beats, compare on done beats
  always @(posedge clk) begin
    logic [ANGLE_WIDTH-1:0] want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (done) begin
        if (angle_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result angle=%0d", angle);
        end else begin
          want = angle_q.pop_front();
          if (want !== angle) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("angle mismatch: expected %0d got %0d",
                       $signed(want), angle);
          end
        end
      end
      if (start && !busy) angle_q.push_back(predict_angle(numerator, denominator));
    end
  end
endmodule

FILE: sim/tb_atan2_poly_approx.sv
// Testbench top: drives operand pairs into the atan2 block and reports the verdict.
module tb_atan2_poly_approx;
  import a2p_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic signed [OPERAND_WIDTH-1:0] numerator = '0, denominator = '0;
  logic signed [ANGLE_WIDTH-1:0] angle;
  int fail_count, pending;
  int idle_cycles = 0;

  localparam int WATCHDOG = 2000;

  always #5 clk = ~clk;

  atan2_poly_approx DUT (.*);

  atan2_poly_approx_checker u_checker (.*);

  // Watchdog on cycles with neither an accepted beat nor a done beat
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("atan2_poly_approx verification failed");
      $finish;
    end
  end

  // Hold one beat until accepted
  task automatic send_beat(input logic [15:0] y, input logic [15:0] x);
    numerator <= y;
    denominator <= x;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'(32'($urandom_range(0, 6)) - 3);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2: return 16'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 16'hffff : 16'h0);
      default: return 16'($urandom);
    endcase
  endfunction

  logic [15:0] dir_y[] = '{16'h0000, 16'h0001, 16'hffff, 16'h0000, 16'h0000, 16'h7fff,
                           16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'd7, 16'd5,
                           16'd1, 16'd2, 16'hfff9, 16'd3, 16'h7fff, 16'h8000, 16'd1};
  logic [15:0] dir_x[] = '{16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h7fff,
                           16'h8000, 16'h8000, 16'h7fff, 16'h0001, 16'd5, 16'd7,
                           16'd2, 16'd1, 16'hfffb, 16'hfffa, 16'h8000, 16'h0000, 16'h8000};

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_y[i]) send_beat(dir_y[i], dir_x[i]);
    start <= 0;
    // Drain completely once before the random part
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Random bursts, most followed by a random gap
    n = 0;
    while (n < 650) begin
      repeat ($urandom_range(1, 30)) begin
        send_beat(rand_operand(), rand_operand());
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 45)) @(posedge clk);
      end
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("atan2_poly_approx verification clean");
    else $display("atan2_poly_approx verification failed");
    $finish;
  end
endmodule
